// File: sv/sorted_multiset_range_sum_macros.svh
// Assertion macros shared by the checker of the sorted multiset block.
// No dependencies; expects i_clk and i_rst_n in the scope of use.
`ifndef SORTED_MULTISET_RANGE_SUM_MACROS_SVH
`define SORTED_MULTISET_RANGE_SUM_MACROS_SVH

// same-cycle implication
`define SMRS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("smrs assertion failed");

// next-cycle implication
`define SMRS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("smrs assertion failed");

`endif

// File: sv/smrs_pkg.sv
// Shared types and codes for the sorted multiset block.
// No dependencies; imported by the cell, scan and top modules.
package smrs_pkg;

    localparam int CMD_W    = 4;
    localparam int KEY_W    = 32;
    localparam int POS_W    = 10;
    localparam int RANGE_W  = 11;
    localparam int SUM_W    = 48;
    localparam int OUTCNT_W = 11;
    localparam int STATUS_W = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD        = 4'd0,
        CMD_DISCARD    = 4'd1,
        CMD_KTH        = 4'd2,
        CMD_LT         = 4'd3,
        CMD_LE         = 4'd4,
        CMD_GT         = 4'd5,
        CMD_GE         = 4'd6,
        CMD_RANK_LEFT  = 4'd7,
        CMD_RANK_RIGHT = 4'd8,
        CMD_COUNT      = 4'd9,
        CMD_CONTAINS   = 4'd10,
        CMD_RANGE_SUM  = 4'd11,
        CMD_SUM_LIMIT  = 4'd12
    } t_cmd;

    localparam logic [STATUS_W-1:0] ST_DONE   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd2;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_ROT,
        OP_INS,
        OP_DEL
    } t_cell_op;

    typedef struct packed {
        logic start;
        logic step;
    } t_scan_ctl;

endpackage

// File: sv/smrs_cell.sv
// One storage cell of the sorted chain: holds one value, shifts on insert,
// delete and scan rotation. Depends on smrs_pkg.
module smrs_cell import smrs_pkg::*; #(
    parameter int VW  = 32,
    parameter int CW  = 11,
    parameter int IDX = 0
) (
    input  logic                 i_clk,
    input  t_cell_op             i_op,
    input  logic signed [VW-1:0] i_key,
    input  logic [CW-1:0]        i_count,
    input  logic signed [VW-1:0] i_prev_val,
    input  logic                 i_prev_ge,
    input  logic signed [VW-1:0] i_next_val,
    output logic signed [VW-1:0] o_val,
    output logic                 o_ge
);

    logic signed [VW-1:0] r_val;
    logic signed [VW-1:0] n_val;
    logic                 occ;

    assign occ   = CW'(IDX) < i_count;
    assign o_ge  = occ && (r_val >= i_key);
    assign o_val = r_val;

    always_comb begin
        n_val = r_val;
        case (i_op)
            OP_ROT: n_val = i_next_val;
            OP_INS: begin
                // everything at or after the insert point moves up one
                if (i_prev_ge) n_val = i_prev_val;
                else if (o_ge || !occ) n_val = i_key;
            end
            OP_DEL: if (o_ge) n_val = i_next_val;
            default: n_val = r_val;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

endmodule

// File: sv/smrs_scan.sv
// Query accumulator fed by the head cell during a full rotation of the chain.
// Depends on smrs_pkg.
module smrs_scan import smrs_pkg::*; #(
    parameter int VW  = 32,
    parameter int CW  = 11,
    parameter int CAW = 10
) (
    input  logic                      i_clk,
    input  t_scan_ctl                 i_ctl,
    input  t_cmd                      i_cmd,
    input  logic signed [VW-1:0]      i_key,
    input  logic [POS_W-1:0]          i_pos,
    input  logic [RANGE_W-1:0]        i_lo,
    input  logic [RANGE_W-1:0]        i_hi,
    input  logic signed [SUM_W-1:0]   i_limit,
    input  logic signed [VW-1:0]      i_val,
    input  logic [CAW-1:0]            i_idx,
    input  logic [CW-1:0]             i_count,
    output logic signed [VW-1:0]      o_val,
    output logic                      o_found,
    output logic [CW-1:0]             o_cnt,
    output logic signed [SUM_W-1:0]   o_sum
);

    localparam int PW = (VW + CW + 1 > SUM_W + 1) ? VW + CW + 1 : SUM_W + 1;

    logic signed [VW-1:0]    r_val;
    logic                    r_found;
    logic [CW-1:0]           r_cnt;
    logic signed [SUM_W-1:0] r_sum;
    logic signed [PW-1:0]    r_prefix;
    logic                    r_stop;

    logic                    occ;
    logic                    in_range;
    logic signed [PW-1:0]    next_prefix;

    assign occ         = CW'(i_idx) < i_count;
    assign in_range    = (32'(i_idx) >= 32'(i_lo)) && (32'(i_idx) < 32'(i_hi));
    assign next_prefix = r_prefix + PW'(i_val);

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_found  <= 1'b0;
            r_cnt    <= '0;
            r_sum    <= '0;
            r_prefix <= '0;
            r_stop   <= 1'b0;
            r_val    <= '0;
        end else if (i_ctl.step && occ) begin
            case (i_cmd) inside
                CMD_KTH: if (32'(i_idx) == 32'(i_pos)) begin
                    r_val   <= i_val;
                    r_found <= 1'b1;
                end
                // last element below the key wins
                CMD_LT: if (i_val < i_key) begin
                    r_val   <= i_val;
                    r_found <= 1'b1;
                end
                CMD_LE: if (i_val <= i_key) begin
                    r_val   <= i_val;
                    r_found <= 1'b1;
                end
                // first element above the key (or equal to it, for GE) wins
                CMD_GT: if (i_val > i_key && !r_found) begin
                    r_val   <= i_val;
                    r_found <= 1'b1;
                end
                CMD_GE: if (i_val >= i_key && !r_found) begin
                    r_val   <= i_val;
                    r_found <= 1'b1;
                end
                CMD_RANK_LEFT:  if (i_val < i_key) r_cnt <= r_cnt + 1'b1;
                CMD_RANK_RIGHT: if (i_val <= i_key) r_cnt <= r_cnt + 1'b1;
                CMD_COUNT, CMD_CONTAINS, CMD_DISCARD: if (i_val == i_key) begin
                    r_cnt   <= r_cnt + 1'b1;
                    r_found <= 1'b1;
                end
                CMD_RANGE_SUM: if (in_range) r_sum <= r_sum + SUM_W'(i_val);
                CMD_SUM_LIMIT: if (!r_stop) begin
                    if (PW'(i_limit) > next_prefix) begin
                        r_prefix <= next_prefix;
                        r_cnt    <= r_cnt + 1'b1;
                    end else begin
                        r_stop <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_val   = r_val;
    assign o_found = r_found;
    assign o_cnt   = r_cnt;
    assign o_sum   = r_sum;

endmodule

// File: sv/sorted_multiset_range_sum.sv
// Top level of the sorted multiset: chain of value cells, scan unit, control.
// Depends on smrs_pkg, smrs_cell, smrs_scan.
//
//  channel  | handshake                   | payload
//  input    | i_in_valid / o_in_ready     | i_command i_key i_position i_range_* i_sum_limit
//  output   | o_out_valid / i_out_ready   | o_value_out o_found o_rank_out o_sum_out ...
//  config   | i_cfg_we                    | i_cfg_data (missing value)
//
// add: one shift of the cell chain in S_INS, then the result is loaded in S_DONE.
// Every other command rotates the whole chain past the head cell once in S_SCAN;
// discard then does the closing shift in S_DEL.
// One item is in work at a time; the output register holds a result while the
// next item is accepted. Reset (synchronous) empties the store, missing value 0.
// A finished item waits in its last state while the previous result is unread.
module sorted_multiset_range_sum import smrs_pkg::*; #(
    parameter int CAPACITY    = 1024,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [CMD_W-1:0]           i_command,
    input  logic signed [KEY_W-1:0]    i_key,
    input  logic [POS_W-1:0]           i_position,
    input  logic [RANGE_W-1:0]         i_range_start,
    input  logic [RANGE_W-1:0]         i_range_end,
    input  logic signed [SUM_W-1:0]    i_sum_limit,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic signed [KEY_W-1:0]    o_value_out,
    output logic                       o_found,
    output logic [OUTCNT_W-1:0]        o_rank_out,
    output logic signed [SUM_W-1:0]    o_sum_out,
    output logic [OUTCNT_W-1:0]        o_element_count,
    output logic [STATUS_W-1:0]        o_status,
    input  logic                       i_cfg_we,
    input  logic signed [KEY_W-1:0]    i_cfg_data
);

    localparam int VW  = VALUE_WIDTH;
    localparam int CAW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW  = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS,
        S_SCAN,
        S_DEL,
        S_DONE
    } t_state;

    t_state                  r_state;
    t_cmd                    r_cmd;
    logic signed [VW-1:0]    r_key;
    logic [POS_W-1:0]        r_pos;
    logic [RANGE_W-1:0]      r_lo;
    logic [RANGE_W-1:0]      r_hi;
    logic signed [SUM_W-1:0] r_limit;
    logic signed [KEY_W-1:0] r_missing;
    logic [CW-1:0]           r_count;
    logic [CAW-1:0]          r_idx;
    logic [STATUS_W-1:0]     r_status;
    logic                    r_ins_ok;

    t_cell_op                cell_op;
    t_scan_ctl               scan_ctl;
    logic signed [VW-1:0]    cell_val [CAPACITY];
    logic                    cell_ge  [CAPACITY];

    logic signed [VW-1:0]    sc_val;
    logic                    sc_found;
    logic [CW-1:0]           sc_cnt;
    logic signed [SUM_W-1:0] sc_sum;
    logic                    accept;
    logic                    is_value_cmd;

    assign accept     = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        cell_op = OP_HOLD;
        if (r_state == S_SCAN) cell_op = OP_ROT;
        else if (r_state == S_INS && r_count < CW'(CAPACITY)) cell_op = OP_INS;
        else if (r_state == S_DEL && sc_found) cell_op = OP_DEL;
    end

    assign scan_ctl.start = accept;
    assign scan_ctl.step  = (r_state == S_SCAN);

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [VW-1:0] prev_val;
        logic                 prev_ge;
        logic signed [VW-1:0] next_val;
        if (g == 0) begin : g_head
            assign prev_val = cell_val[0];
            assign prev_ge  = 1'b0;
        end else begin : g_body
            assign prev_val = cell_val[g-1];
            assign prev_ge  = cell_ge[g-1];
        end
        // the tail wraps to the head so a full rotation restores order
        assign next_val = cell_val[(g + 1) % CAPACITY];

        smrs_cell #(.VW(VW), .CW(CW), .IDX(g)) u_cell (
            .i_clk      (i_clk),
            .i_op       (cell_op),
            .i_key      (r_key),
            .i_count    (r_count),
            .i_prev_val (prev_val),
            .i_prev_ge  (prev_ge),
            .i_next_val (next_val),
            .o_val      (cell_val[g]),
            .o_ge       (cell_ge[g])
        );
    end

    smrs_scan #(.VW(VW), .CW(CW), .CAW(CAW)) u_scan (
        .i_clk   (i_clk),
        .i_ctl   (scan_ctl),
        .i_cmd   (r_cmd),
        .i_key   (r_key),
        .i_pos   (r_pos),
        .i_lo    (r_lo),
        .i_hi    (r_hi),
        .i_limit (r_limit),
        .i_val   (cell_val[0]),
        .i_idx   (r_idx),
        .i_count (r_count),
        .o_val   (sc_val),
        .o_found (sc_found),
        .o_cnt   (sc_cnt),
        .o_sum   (sc_sum)
    );

    assign is_value_cmd = (r_cmd == CMD_KTH) || (r_cmd == CMD_LT) || (r_cmd == CMD_LE)
                       || (r_cmd == CMD_GT) || (r_cmd == CMD_GE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_missing   <= '0;
            o_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) r_missing <= i_cfg_data;
            // S_DONE reloads the output register itself
            if (o_out_valid && i_out_ready && r_state != S_DONE) o_out_valid <= 1'b0;

            unique case (r_state)
                S_IDLE: if (accept) begin
                    r_cmd    <= t_cmd'(i_command);
                    r_key    <= VW'(i_key);
                    r_pos    <= i_position;
                    r_lo     <= i_range_start;
                    r_hi     <= i_range_end;
                    r_limit  <= i_sum_limit;
                    r_idx    <= '0;
                    r_status <= ST_DONE;
                    r_ins_ok <= 1'b0;
                    r_state  <= (t_cmd'(i_command) == CMD_ADD) ? S_INS : S_SCAN;
                end
                S_INS: begin
                    if (r_count < CW'(CAPACITY)) begin
                        r_count  <= r_count + 1'b1;
                        r_ins_ok <= 1'b1;
                    end else begin
                        r_status <= ST_FULL;
                    end
                    r_state <= S_DONE;
                end
                S_SCAN: begin
                    r_idx <= r_idx + 1'b1;
                    if (r_idx == CAW'(CAPACITY - 1))
                        r_state <= (r_cmd == CMD_DISCARD) ? S_DEL : S_DONE;
                end
                S_DEL: begin
                    if (sc_found) r_count <= r_count - 1'b1;
                    else r_status <= ST_ABSENT;
                    r_state <= S_DONE;
                end
                S_DONE: if (!o_out_valid || i_out_ready) begin
                    o_out_valid     <= 1'b1;
                    o_value_out     <= is_value_cmd ? (sc_found ? KEY_W'(sc_val) : r_missing)
                                                    : '0;
                    case (r_cmd) inside
                        CMD_ADD: o_found <= r_ins_ok;
                        CMD_DISCARD, CMD_KTH, CMD_LT, CMD_LE, CMD_GT, CMD_GE,
                        CMD_COUNT, CMD_CONTAINS: o_found <= sc_found;
                        default: o_found <= 1'b0;
                    endcase
                    case (r_cmd) inside
                        CMD_RANK_LEFT, CMD_RANK_RIGHT, CMD_COUNT, CMD_SUM_LIMIT:
                            o_rank_out <= OUTCNT_W'(sc_cnt);
                        default: o_rank_out <= '0;
                    endcase
                    o_sum_out       <= (r_cmd == CMD_RANGE_SUM) ? sc_sum : '0;
                    o_element_count <= OUTCNT_W'(r_count);
                    o_status        <= r_status;
                    r_state         <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// File: sv/smrs_checker.sv
// Port-level checker for the sorted multiset block, bound to the top level.
// Depends on smrs_pkg and sorted_multiset_range_sum_macros.svh.
`include "sorted_multiset_range_sum_macros.svh"

module smrs_checker import smrs_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic       o_found,
    input logic [1:0] o_status
);

    `SMRS_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid)
    `SMRS_ASSERT_NEXT(a_one_in_flight, i_in_valid && o_in_ready, !o_in_ready)
    `SMRS_ASSERT_NOW(a_status_code, o_out_valid, o_status <= ST_ABSENT)
    `SMRS_ASSERT_NOW(a_fail_not_found, o_out_valid && o_status != ST_DONE, !o_found)

endmodule

bind sorted_multiset_range_sum smrs_checker u_smrs_checker (.*);

// File: dv/tb_sorted_multiset_range_sum.sv
// Testbench for sorted_multiset_range_sum: random and directed commands, scoreboard check.
// Depends on smrs_pkg and the block; self-contained predictor keeps its own sorted store.
`timescale 1ns / 1ps

module tb_sorted_multiset_range_sum;
    import smrs_pkg::*;

    localparam int CAP = 1024;

    typedef struct {
        logic [CMD_W-1:0]        command;
        logic signed [KEY_W-1:0] key;
        logic [POS_W-1:0]        position;
        logic [RANGE_W-1:0]      range_start;
        logic [RANGE_W-1:0]      range_end;
        logic signed [SUM_W-1:0] sum_limit;
    } t_req;

    typedef struct {
        logic signed [KEY_W-1:0] value_out;
        logic                    found;
        logic [OUTCNT_W-1:0]     rank_out;
        logic signed [SUM_W-1:0] sum_out;
        logic [OUTCNT_W-1:0]     element_count;
        logic [STATUS_W-1:0]     status;
    } t_resp;

    logic i_clk = 0, i_rst_n = 0;
    logic i_in_valid = 0, i_out_ready = 0, i_cfg_we = 0;
    logic o_in_ready, o_out_valid, o_found;
    logic [CMD_W-1:0] i_command = '0;
    logic signed [KEY_W-1:0] i_key = '0, i_cfg_data = '0, o_value_out;
    logic [POS_W-1:0] i_position = '0;
    logic [RANGE_W-1:0] i_range_start = '0, i_range_end = '0;
    logic signed [SUM_W-1:0] i_sum_limit = '0, o_sum_out;
    logic [OUTCNT_W-1:0] o_rank_out, o_element_count;
    logic [STATUS_W-1:0] o_status;

    sorted_multiset_range_sum u_top (.*);

    initial forever #10 i_clk = ~i_clk;

    // predictor state
    longint mset[$];
    logic signed [KEY_W-1:0] miss_val = 0;

    t_req  pending_reqs[$];
    t_resp expected_resps[$];
    int    n_errors = 0;
    bit    feed_done = 0;

    function automatic int lower_idx(longint k, bit strict);
        int lo, hi, mid;
        lo = 0; hi = mset.size();
        while (lo < hi) begin
            mid = (lo + hi) / 2;
            if (strict ? (mset[mid] <= k) : (mset[mid] < k)) lo = mid + 1;
            else hi = mid;
        end
        return lo;
    endfunction

    function automatic t_resp multiset_apply(t_req q);
        t_resp r;
        int a, b, n, lo, hi;
        longint k, acc, pre;
        r = '{default: '0};
        k = q.key;
        n = mset.size();
        case (q.command)
            CMD_ADD: begin
                if (n >= CAP) r.status = ST_FULL;
                else begin
                    mset.insert(lower_idx(k, 1'b0), k);
                    r.found = 1;
                end
            end
            CMD_DISCARD: begin
                a = lower_idx(k, 1'b0);
                if (a >= n || mset[a] != k) r.status = ST_ABSENT;
                else begin
                    mset.delete(a);
                    r.found = 1;
                end
            end
            CMD_KTH: begin
                if (q.position < n) begin
                    r.value_out = KEY_W'(mset[q.position]); r.found = 1;
                end else r.value_out = miss_val;
            end
            CMD_LT, CMD_LE: begin
                a = lower_idx(k, q.command == CMD_LE);
                if (a > 0) begin r.value_out = KEY_W'(mset[a-1]); r.found = 1; end
                else r.value_out = miss_val;
            end
            CMD_GT, CMD_GE: begin
                a = lower_idx(k, q.command == CMD_GT);
                if (a < n) begin r.value_out = KEY_W'(mset[a]); r.found = 1; end
                else r.value_out = miss_val;
            end
            CMD_RANK_LEFT:  r.rank_out = OUTCNT_W'(lower_idx(k, 1'b0));
            CMD_RANK_RIGHT: r.rank_out = OUTCNT_W'(lower_idx(k, 1'b1));
            CMD_COUNT, CMD_CONTAINS: begin
                a = lower_idx(k, 1'b0);
                b = lower_idx(k, 1'b1);
                r.found = b > a;
                if (q.command == CMD_COUNT) r.rank_out = OUTCNT_W'(b - a);
            end
            CMD_RANGE_SUM: begin
                lo = (q.range_start > n) ? n : q.range_start;
                hi = (q.range_end > n) ? n : q.range_end;
                acc = 0;
                for (int i = lo; i < hi; i++) acc += mset[i];
                r.sum_out = acc[SUM_W-1:0];
            end
            CMD_SUM_LIMIT: begin
                pre = 0; a = 0;
                while (a < n && longint'(q.sum_limit) > pre + mset[a]) begin
                    pre += mset[a]; a++;
                end
                r.rank_out = OUTCNT_W'(a);
            end
            default: ;
        endcase
        r.element_count = OUTCNT_W'(mset.size());
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        n_errors++;
    endtask

    task automatic enqueue(t_req q);
        pending_reqs.insert(pending_reqs.size(), q);
    endtask

    // driver: bursts and gaps
    int burst_left = 0, gap_left = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                expected_resps.insert(expected_resps.size(),
                                      multiset_apply(pending_reqs.pop_front()));
            end
            if (!i_in_valid || o_in_ready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    i_in_valid <= 0;
                end else if (pending_reqs.size() > 0) begin
                    t_req q;
                    // head of the queue is the next item once the accepted one is gone
                    q = pending_reqs[0];
                    i_in_valid    <= 1;
                    i_command     <= q.command;
                    i_key         <= q.key;
                    i_position    <= q.position;
                    i_range_start <= q.range_start;
                    i_range_end   <= q.range_end;
                    i_sum_limit   <= q.sum_limit;
                    if (burst_left > 0) burst_left <= burst_left - 1;
                    else begin
                        burst_left <= $urandom_range(0, 20);
                        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
                    end
                end else i_in_valid <= 0;
            end
        end
    end

    // monitor plus receiver stall pattern
    int stall_phase = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            stall_phase <= stall_phase + 1;
            i_out_ready <= (stall_phase[7:6] == 2'd0) ? 1'b1 : ($urandom_range(0, 2) != 0);
            if (o_out_valid && i_out_ready) begin
                if (expected_resps.size() == 0) begin
                    report_mismatch("unexpected result item", 1, 0);
                end else begin
                    t_resp e;
                    e = expected_resps.pop_front();
                    if (o_value_out !== e.value_out)
                        report_mismatch("value_out", o_value_out, e.value_out);
                    if (o_found !== e.found) report_mismatch("found", o_found, e.found);
                    if (o_rank_out !== e.rank_out)
                        report_mismatch("rank_out", o_rank_out, e.rank_out);
                    if (o_sum_out !== e.sum_out) report_mismatch("sum_out", o_sum_out, e.sum_out);
                    if (o_element_count !== e.element_count)
                        report_mismatch("element_count", o_element_count, e.element_count);
                    if (o_status !== e.status) report_mismatch("status", o_status, e.status);
                end
            end
        end
    end

    function automatic logic signed [KEY_W-1:0] pick_key();
        case ($urandom_range(0, 5))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return $urandom;
            default: return $signed($urandom_range(0, 40)) - 20;
        endcase
    endfunction

    function automatic t_req make_req(logic [CMD_W-1:0] c, logic signed [KEY_W-1:0] k);
        t_req q;
        q.command     = c;
        q.key         = k;
        q.position    = POS_W'(($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 40));
        q.range_start = RANGE_W'(($urandom_range(0, 4) == 0) ? $urandom
                                                              : $urandom_range(0, 40));
        q.range_end   = RANGE_W'(($urandom_range(0, 4) == 0) ? $urandom
                                                              : $urandom_range(0, 40));
        case ($urandom_range(0, 3))
            0: q.sum_limit = SUM_W'({$urandom, $urandom});
            1: q.sum_limit = 48'sh7fffffffffff;
            2: q.sum_limit = 48'sh800000000000;
            default: q.sum_limit = SUM_W'($signed($urandom_range(0, 400)) - 200);
        endcase
        return q;
    endfunction

    task automatic wait_idle();
        while (pending_reqs.size() != 0 || i_in_valid || expected_resps.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic drain_and_config(logic signed [KEY_W-1:0] v);
        wait_idle();
        repeat (CAP + 10) @(posedge i_clk);
        i_cfg_we   <= 1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we   <= 0;
        miss_val = v;
    endtask

    task automatic queue_random(int count, int add_bias);
        logic [CMD_W-1:0] c;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 99) < add_bias) c = CMD_ADD;
            else c = CMD_W'($urandom_range(0, 15));
            enqueue(make_req(c, pick_key()));
        end
    endtask

    initial begin
        t_req q;
        int fill;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        drain_and_config(32'sh80000000);
        // directed: queries on an empty store, extremes, duplicates, absent discard
        for (int c = 0; c < 16; c++) enqueue(make_req(CMD_W'(c), '0));
        enqueue(make_req(CMD_ADD, 32'sh7fffffff));
        enqueue(make_req(CMD_ADD, 32'sh80000000));
        enqueue(make_req(CMD_ADD, 5));
        enqueue(make_req(CMD_ADD, 5));
        enqueue(make_req(CMD_COUNT, 5));
        enqueue(make_req(CMD_DISCARD, 6));
        q = make_req(CMD_RANGE_SUM, 0);
        q.range_start = '0; q.range_end = RANGE_W'(1024);
        enqueue(q);
        q = make_req(CMD_KTH, 0); q.position = 10'h3ff;
        enqueue(q);
        queue_random(40, 35);
        drain_and_config(32'sh7fffffff);
        queue_random(40, 20);
        drain_and_config($urandom);
        queue_random(40, 30);
        wait_idle();
        // fill to capacity so a refused insert and wide counts get exercised
        fill = CAP - mset.size() + 3;
        for (int i = 0; i < fill; i++) enqueue(make_req(CMD_ADD, pick_key()));
        queue_random(24, 0);
        feed_done = 1;
    end

    initial begin
        wait (feed_done);
        while (pending_reqs.size() != 0 || i_in_valid || expected_resps.size() != 0)
            @(posedge i_clk);
        repeat (CAP + 20) @(posedge i_clk);
        if (n_errors == 0) $display("ALL CHECKS PASSED");
        else $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        #(64'd200_000_000);
        $display("CHECKS FAILED");
        $finish;
    end
endmodule
